[rtl/core/hsed_pkg.sv]
// ----------------------------------------------------------------------------
// hsed_pkg
// Shared constants, types and helper functions for the Hamming SEC
// encoder/checker.
// ----------------------------------------------------------------------------
package hsed_pkg;

  localparam int unsigned MaxDataBits = 57;
  localparam int unsigned DataW       = 57;
  localparam int unsigned CodeW       = 63;
  localparam int unsigned SynW        = 6;
  localparam int unsigned StatusW     = 2;
  localparam int unsigned CfgW        = 6;
  localparam int unsigned ParMax      = 6;

  localparam logic [CfgW-1:0] DataBitsRst = CfgW'(4);

  typedef enum logic [StatusW-1:0] {
    StClean = 2'd0,
    StFixed = 2'd1,
    StRange = 2'd2
  } status_e;

  typedef enum logic {
    FuncEncode = 1'b0,
    FuncDecode = 1'b1
  } func_e;

  // Clamps the configured data bit count and returns the code length k + r.
  function automatic logic [SynW-1:0] code_len(logic [CfgW-1:0] cfg);
    logic [CfgW-1:0] k;
    logic [SynW-1:0] r;
    k = cfg;
    if (k == '0) begin
      k = CfgW'(1);
    end else if (k > CfgW'(MaxDataBits)) begin
      k = CfgW'(MaxDataBits);
    end
    priority if (k <= CfgW'(1)) begin
      r = SynW'(2);
    end else if (k <= CfgW'(4)) begin
      r = SynW'(3);
    end else if (k <= CfgW'(11)) begin
      r = SynW'(4);
    end else if (k <= CfgW'(26)) begin
      r = SynW'(5);
    end else begin
      r = SynW'(6);
    end
    return SynW'(k) + r;
  endfunction

  // Places data bits in order at every position that is not a power of two.
  function automatic logic [CodeW-1:0] place_data(logic [DataW-1:0] d);
    logic [CodeW-1:0] w;
    logic [5:0]       di;
    w  = '0;
    di = '0;
    for (int p = 1; p <= CodeW; p++) begin
      if ((p & (p - 1)) != 0) begin
        w[p-1] = d[di];
        di     = di + 6'd1;
      end
    end
    return w;
  endfunction

  // Positions whose number has bit j set.
  function automatic logic [CodeW-1:0] pos_mask(int unsigned j);
    logic [CodeW-1:0] m;
    m = '0;
    for (int p = 1; p <= CodeW; p++) begin
      m[p-1] = ((p >> j) & 1) != 0;
    end
    return m;
  endfunction

endpackage

[rtl/core/hsed_cfg_if.sv]
// ----------------------------------------------------------------------------
// hsed_cfg_if
// Configuration write channel carrying the data bit count.
// ----------------------------------------------------------------------------
interface hsed_cfg_if;
  import hsed_pkg::*;

  logic            valid;
  logic            ready;
  logic [CfgW-1:0] data_bits;

  modport source (output valid, output data_bits, input ready);
  modport sink   (input valid, input data_bits, output ready);
endinterface

[rtl/core/hsed_in_if.sv]
// ----------------------------------------------------------------------------
// hsed_in_if
// Input channel: one item is a function select and its data or codeword.
// ----------------------------------------------------------------------------
interface hsed_in_if;
  import hsed_pkg::*;

  logic             valid;
  logic             ready;
  logic             func;
  logic [DataW-1:0] data_word;
  logic [CodeW-1:0] received_code;

  modport source (output valid, output func, output data_word, output received_code,
                  input ready);
  modport sink   (input valid, input func, input data_word, input received_code,
                  output ready);
endinterface

[rtl/core/hsed_out_if.sv]
// ----------------------------------------------------------------------------
// hsed_out_if
// Output channel: one item is a codeword, its syndrome and a status code.
// ----------------------------------------------------------------------------
interface hsed_out_if;
  import hsed_pkg::*;

  logic               valid;
  logic               ready;
  logic [CodeW-1:0]   result_code;
  logic [SynW-1:0]    syndrome;
  logic [StatusW-1:0] status;

  modport source (output valid, output result_code, output syndrome, output status,
                  input ready);
  modport sink   (input valid, input result_code, input syndrome, input status,
                  output ready);
endinterface

[rtl/core/hamming_sec_encode_decode.sv]
// ----------------------------------------------------------------------------
// hamming_sec_encode_decode
// Even-parity Hamming single-error-correcting encoder and checker with a
// configurable number of data bits.
// ----------------------------------------------------------------------------
// Pipeline: an input register holds the accepted item, then a result register
// holds the parity/syndrome logic output.
// Throughput: one item per cycle while the output is not stalled; a stalled
// output holds the result register and the input register fills behind it.
// Reset: both stages empty, data bit count set to 4 (7-bit code).
// ----------------------------------------------------------------------------
module hamming_sec_encode_decode (
  input  logic         clk_i,
  input  logic         rst_ni,
  hsed_cfg_if.sink     cfg_i,
  hsed_in_if.sink      in_i,
  hsed_out_if.source   out_o
);
  import hsed_pkg::*;

  logic [CfgW-1:0]    data_bits_q;

  logic               s1_valid_q;
  logic               s1_func_q;
  logic [DataW-1:0]   s1_data_q;
  logic [CodeW-1:0]   s1_rx_q;

  logic               out_valid_q;
  logic [CodeW-1:0]   out_code_q;
  logic [SynW-1:0]    out_syn_q;
  logic [StatusW-1:0] out_status_q;

  logic [CodeW-1:0]   out_code_d;
  logic [SynW-1:0]    out_syn_d;
  status_e            out_status_d;

  logic               s1_take;
  logic [SynW-1:0]    len;
  logic [CodeW-1:0]   len_mask;
  logic [CodeW-1:0]   word;
  logic [SynW-1:0]    syn;
  logic [CodeW-1:0]   par_bits;
  logic [CodeW-1:0]   flip;

  assign cfg_i.ready = 1'b1;

  assign s1_take    = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s1_take;

  assign len      = code_len(data_bits_q);
  assign len_mask = ~({CodeW{1'b1}} << len);

  always_comb begin
    word     = (s1_func_q == FuncDecode) ? s1_rx_q : place_data(s1_data_q);
    word     = word & len_mask;
    par_bits = '0;
    for (int unsigned j = 0; j < ParMax; j++) begin
      syn[j] = ^(word & pos_mask(j));
      par_bits[(1 << j) - 1] = syn[j];
    end
    flip = {{(CodeW-1){1'b0}}, 1'b1} << (syn - SynW'(1));
  end

  always_comb begin
    out_code_d   = word | par_bits;
    out_syn_d    = '0;
    out_status_d = StClean;
    if (s1_func_q == FuncDecode) begin
      out_code_d = word;
      out_syn_d  = syn;
      if (syn != '0) begin
        if (syn <= len) begin
          out_code_d   = word ^ flip;
          out_status_d = StFixed;
        end else begin
          out_status_d = StRange;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_bits_q <= DataBitsRst;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        data_bits_q <= cfg_i.data_bits;
      end
      if (in_i.ready) begin
        s1_valid_q <= in_i.valid;
      end
      if (s1_take) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_func_q <= in_i.func;
      s1_data_q <= in_i.data_word;
      s1_rx_q   <= in_i.received_code;
    end
    if (s1_take && s1_valid_q) begin
      out_code_q   <= out_code_d;
      out_syn_q    <= out_syn_d;
      out_status_q <= out_status_d;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.result_code = out_code_q;
  assign out_o.syndrome    = out_syn_q;
  assign out_o.status      = out_status_q;

endmodule

[sim/tb_hamming_sec_encode_decode.sv]
// ----------------------------------------------------------------------------
// tb_hamming_sec_encode_decode
// Self-checking testbench for the Hamming SEC encoder and checker. A queue of
// pending items feeds a clocked driver, and a clocked monitor compares every
// result item with the oldest prediction. The data bit count is swept over
// in-range, boundary and out-of-range settings, with random stalls on both
// channels.
// ----------------------------------------------------------------------------
module tb_hamming_sec_encode_decode;
  timeunit 1ns;
  timeprecision 1ps;

  import hsed_pkg::*;

  localparam int unsigned ItemsPerPhase = 96;
  localparam int unsigned NumPhases     = 13;
  localparam int unsigned HoldAtItem    = 200;
  localparam int unsigned HoldCycles    = 300;
  localparam int unsigned CycleLimit    = 200000;

  typedef struct packed {
    func_e            func;
    logic [DataW-1:0] data_word;
    logic [CodeW-1:0] received_code;
  } code_item_t;

  typedef struct packed {
    logic [CodeW-1:0] result_code;
    logic [SynW-1:0]  syndrome;
    status_e          status;
  } code_result_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  hsed_cfg_if cfg_if ();
  hsed_in_if  in_if ();
  hsed_out_if out_if ();

  hamming_sec_encode_decode i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #5 clk_i = ~clk_i;

  code_item_t      pending_items[$];
  code_result_t    expected_results[$];
  logic [CfgW-1:0] cur_data_bits = DataBitsRst;
  int unsigned     items_queued   = 0;
  int unsigned     items_accepted = 0;
  int unsigned     fail_cnt       = 0;
  int unsigned     cycle_cnt      = 0;
  int unsigned     send_idle_pct  = 37;
  int unsigned     recv_idle_pct  = 58;
  int unsigned     hold_left      = 0;
  logic            hold_done      = 1'b0;

  function automatic int unsigned code_length_of(logic [CfgW-1:0] cfg);
    int unsigned k;
    int unsigned r;
    k = cfg;
    if (k < 1) k = 1;
    if (k > MaxDataBits) k = MaxDataBits;
    r = 0;
    while ((1 << r) < k + r + 1) r++;
    return k + r;
  endfunction

  function automatic code_result_t hamming_predict(logic [CfgW-1:0] cfg, code_item_t item);
    code_result_t     res;
    logic [CodeW-1:0] w;
    int unsigned      n;
    int unsigned      di;
    int unsigned      s;
    int unsigned      p;
    int unsigned      j;
    n  = code_length_of(cfg);
    w  = '0;
    s  = 0;
    di = 0;
    res.syndrome = '0;
    res.status   = StClean;
    if (item.func == FuncEncode) begin
      for (p = 1; p <= n; p++) begin
        if ((p & (p - 1)) != 0) begin
          w[p-1] = item.data_word[di];
          di++;
        end
      end
      for (p = 1; p <= n; p++) begin
        if (w[p-1]) s ^= p;
      end
      for (j = 0; (1 << j) <= n; j++) begin
        if (((s >> j) & 1) != 0) w[(1 << j) - 1] = 1'b1;
      end
    end else begin
      for (p = 1; p <= n; p++) begin
        w[p-1] = item.received_code[p-1];
        if (w[p-1]) s ^= p;
      end
      res.syndrome = SynW'(s);
      if (s != 0) begin
        if (s <= n) begin
          w[s-1]     = ~w[s-1];
          res.status = StFixed;
        end else begin
          res.status = StRange;
        end
      end
    end
    res.result_code = w;
    return res;
  endfunction

  task automatic queue_item(func_e func, logic [DataW-1:0] data, logic [CodeW-1:0] code);
    code_item_t item;
    item.func          = func;
    item.data_word     = data;
    item.received_code = code;
    pending_items.push_back(item);
    items_queued++;
  endtask

  task automatic queue_random_item();
    code_item_t       item;
    logic [CodeW-1:0] word;
    int unsigned      n;
    int unsigned      kind;
    n    = code_length_of(cur_data_bits);
    kind = $urandom_range(0, 9);
    item.func          = FuncEncode;
    item.data_word     = DataW'({$urandom, $urandom});
    item.received_code = CodeW'({$urandom, $urandom});
    if (kind >= 4 && kind <= 8) begin
      word = hamming_predict(cur_data_bits, item).result_code;
      case ($urandom_range(0, 9))
        0, 1, 2: ;
        3, 4, 5, 6: word[$urandom_range(0, n - 1)] ^= 1'b1;
        7: word[$urandom_range(0, CodeW - 1)] ^= 1'b1;
        default: begin
          word[$urandom_range(0, n - 1)] ^= 1'b1;
          word[$urandom_range(0, n - 1)] ^= 1'b1;
        end
      endcase
      if ($urandom_range(0, 3) == 0) word |= CodeW'({$urandom, $urandom}) << n;
      item.received_code = word;
    end
    if (kind >= 4) item.func = FuncDecode;
    queue_item(item.func, item.data_word, item.received_code);
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (items_accepted != items_queued || expected_results.size() != 0);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_data_bits(logic [CfgW-1:0] value);
    wait_drained();
    @(posedge clk_i);
    cfg_if.valid     <= 1'b1;
    cfg_if.data_bits <= value;
    do @(posedge clk_i);
    while (cfg_if.ready !== 1'b1);
    cfg_if.valid  <= 1'b0;
    cur_data_bits = value;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : drive_proc
    code_item_t item;
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        item.func          = func_e'(in_if.func);
        item.data_word     = in_if.data_word;
        item.received_code = in_if.received_code;
        expected_results.push_back(hamming_predict(cur_data_bits, item));
        items_accepted <= items_accepted + 1;
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_items.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          item = pending_items.pop_front();
          in_if.valid         <= 1'b1;
          in_if.func          <= item.func;
          in_if.data_word     <= item.data_word;
          in_if.received_code <= item.received_code;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_if.ready <= 1'b0;
    end else if (!hold_done && items_accepted >= HoldAtItem) begin
      hold_left    <= HoldCycles;
      hold_done    <= 1'b1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_proc
    code_result_t exp_res;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        fail_cnt++;
        $display("%0t: unexpected result item, expected none actual code %h", $realtime,
                 out_if.result_code);
      end else begin
        exp_res = expected_results.pop_front();
        if (out_if.result_code !== exp_res.result_code) begin
          fail_cnt++;
          $display("%0t: result_code expected %h actual %h", $realtime,
                   exp_res.result_code, out_if.result_code);
        end
        if (out_if.syndrome !== exp_res.syndrome) begin
          fail_cnt++;
          $display("%0t: syndrome expected %0d actual %0d", $realtime,
                   exp_res.syndrome, out_if.syndrome);
        end
        if (out_if.status !== exp_res.status) begin
          fail_cnt++;
          $display("%0t: status expected %0d actual %0d", $realtime,
                   exp_res.status, out_if.status);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    logic [CfgW-1:0] phase_cfg [NumPhases];
    logic [CodeW-1:0] word;
    code_item_t      tmp;
    phase_cfg = '{CfgW'(0), CfgW'(1), CfgW'(57), CfgW'(5), CfgW'(2), CfgW'(63), CfgW'(11),
                  CfgW'(12), CfgW'(26), CfgW'(27), CfgW'(58), CfgW'(3), CfgW'(4)};
    cfg_if.valid         = 1'b0;
    cfg_if.data_bits     = DataBitsRst;
    in_if.valid          = 1'b0;
    in_if.func           = FuncEncode;
    in_if.data_word      = '0;
    in_if.received_code  = '0;
    out_if.ready         = 1'b0;
    rst_ni               = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Reset setting of four data bits, seven-bit code.
    tmp.func          = FuncEncode;
    tmp.data_word     = DataW'(4'b1011);
    tmp.received_code = '0;
    word = hamming_predict(cur_data_bits, tmp).result_code;
    queue_item(FuncEncode, '0, '0);
    queue_item(FuncEncode, '1, '0);
    queue_item(FuncEncode, DataW'(4'b1011), '1);
    queue_item(FuncDecode, '0, '0);
    queue_item(FuncDecode, '0, '1);
    queue_item(FuncDecode, '1, word);
    queue_item(FuncDecode, '0, word ^ CodeW'(7'b0000100));
    queue_item(FuncDecode, '0, word ^ CodeW'(7'b1000000));
    queue_item(FuncDecode, '0, word | {CodeW{1'b1}} << 7);

    write_data_bits(CfgW'(5));
    queue_item(FuncDecode, '0, CodeW'(8'h8B));
    queue_item(FuncDecode, '0, '1);
    queue_item(FuncEncode, '1, '0);

    write_data_bits(CfgW'(57));
    queue_item(FuncEncode, '1, '0);
    queue_item(FuncEncode, '0, '1);
    queue_item(FuncDecode, '0, '1);
    queue_item(FuncDecode, '0, CodeW'(1) << (CodeW - 1));
    queue_item(FuncDecode, '0, CodeW'(1));
    queue_item(FuncEncode, DataW'({DataW/2{2'b10}}), '0);

    write_data_bits(CfgW'(0));
    queue_item(FuncEncode, DataW'(1), '0);
    queue_item(FuncEncode, '1, '0);
    queue_item(FuncDecode, '0, CodeW'(3'b111));
    queue_item(FuncDecode, '0, CodeW'(3'b100));

    write_data_bits(CfgW'(63));
    queue_item(FuncEncode, '1, '0);
    queue_item(FuncDecode, '0, '1);

    for (int ph = 0; ph < NumPhases; ph++) begin
      write_data_bits((ph == NumPhases - 1) ? CfgW'($urandom_range(0, 63)) : phase_cfg[ph]);
      if (ph == 4) begin
        send_idle_pct = 58;
        recv_idle_pct = 37;
      end else if (ph == 9) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      for (int i = 0; i < ItemsPerPhase; i++) queue_random_item();
    end

    wait_drained();
    repeat (10) @(negedge clk_i);
    if (expected_results.size() != 0) fail_cnt++;
    if (fail_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/hsed_pkg.sv
rtl/core/hsed_cfg_if.sv
rtl/core/hsed_in_if.sv
rtl/core/hsed_out_if.sv
rtl/core/hamming_sec_encode_decode.sv
sim/tb_hamming_sec_encode_decode.sv
